[rtl/core/vsfg_pkg.sv]
// vsfg_pkg: constants and glyph stroke table for the stroke font generator
// no dependencies; imported by vector_stroke_font_generator and its testbench
package vsfg_pkg;

   localparam int ROM_ROWS = 96;
   localparam int ROM_COLS = 8;
   localparam int ROW_W    = $clog2(ROM_ROWS);
   localparam int COL_W    = $clog2(ROM_COLS);
   localparam int CNT_W    = $clog2(ROM_COLS + 1);

   localparam logic [7:0] LIFT_CODE = 8'hFE;
   localparam logic [7:0] STOP_CODE = 8'hFF;

   localparam logic [6:0] FIRST_CODE  = 7'h20;
   localparam logic [6:0] LOWER_FIRST = 7'h61;
   localparam logic [6:0] LOWER_LAST  = 7'h7A;
   localparam logic [6:0] FOLD_OFFSET = 7'h20;

   localparam logic [3:0] CELL_UNITS = 4'd12;
   localparam logic [4:0] MIN_WIDE   = 5'd12;
   localparam logic [4:0] WIDE_PAD   = 5'd4;
   localparam logic [7:0] TOP_PAD    = 8'd2;

   localparam logic [7:0] SCALE_RESET = 8'd16;
   localparam int         CSR_ADDR_W  = 3;
   localparam logic       REG_SCALE   = 1'b0;

   localparam logic RESULT_SEGMENT = 1'b0;
   localparam logic RESULT_ADVANCE = 1'b1;

   typedef logic [7:0] glyph_row_type [ROM_COLS];

   // x in the high nibble, y in the low nibble
   localparam glyph_row_type GLYPH_ROM [ROM_ROWS] = '{
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h40, 8'h32, 8'h52, 8'h40, 8'hFE, 8'h44, 8'h4C, 8'hFF},
      '{8'h2A, 8'h26, 8'hFE, 8'h6A, 8'h66, 8'hFF, 8'hFF, 8'hFF},
      '{8'h04, 8'h84, 8'h62, 8'h6A, 8'h88, 8'h08, 8'h2A, 8'h22},
      '{8'h62, 8'h26, 8'h6A, 8'hFE, 8'h4C, 8'h40, 8'hFF, 8'hFF},
      '{8'h00, 8'h8C, 8'hFE, 8'h2A, 8'h28, 8'hFE, 8'h64, 8'h62},
      '{8'h80, 8'h4C, 8'h88, 8'h04, 8'h40, 8'h84, 8'hFF, 8'hFF},
      '{8'h26, 8'h6A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h60, 8'h24, 8'h28, 8'h6C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h20, 8'h64, 8'h68, 8'h2C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h4C, 8'h80, 8'h08, 8'h88, 8'h00, 8'hFF, 8'hFF},
      '{8'h16, 8'h76, 8'hFE, 8'h49, 8'h43, 8'hFF, 8'hFF, 8'hFF},
      '{8'h20, 8'h42, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h26, 8'h66, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h30, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h8C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h80, 8'h8C, 8'h0C, 8'h00, 8'h8C, 8'hFF, 8'hFF},
      '{8'h40, 8'h4C, 8'h3A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h8C, 8'h87, 8'h05, 8'h00, 8'h80, 8'hFF, 8'hFF},
      '{8'h0C, 8'h8C, 8'h80, 8'h00, 8'hFE, 8'h06, 8'h86, 8'hFF},
      '{8'h0C, 8'h06, 8'h86, 8'hFE, 8'h8C, 8'h80, 8'hFF, 8'hFF},
      '{8'h00, 8'h80, 8'h86, 8'h07, 8'h0C, 8'h8C, 8'hFF, 8'hFF},
      '{8'h0C, 8'h00, 8'h80, 8'h85, 8'h07, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h8C, 8'h86, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h80, 8'h8C, 8'h0C, 8'h00, 8'hFE, 8'h06, 8'h86},
      '{8'h80, 8'h8C, 8'h0C, 8'h07, 8'h85, 8'hFF, 8'hFF, 8'hFF},
      '{8'h49, 8'h47, 8'hFE, 8'h45, 8'h43, 8'hFF, 8'hFF, 8'hFF},
      '{8'h49, 8'h47, 8'hFE, 8'h45, 8'h12, 8'hFF, 8'hFF, 8'hFF},
      '{8'h60, 8'h26, 8'h6C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h14, 8'h74, 8'hFE, 8'h18, 8'h78, 8'hFF, 8'hFF, 8'hFF},
      '{8'h20, 8'h66, 8'h2C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h08, 8'h4C, 8'h88, 8'h44, 8'hFE, 8'h41, 8'h40, 8'hFF},
      '{8'h84, 8'h40, 8'h04, 8'h08, 8'h4C, 8'h88, 8'h44, 8'h36},
      '{8'h00, 8'h08, 8'h4C, 8'h88, 8'h80, 8'hFE, 8'h04, 8'h84},
      '{8'h00, 8'h0C, 8'h4C, 8'h8A, 8'h46, 8'h82, 8'h40, 8'h00},
      '{8'h80, 8'h00, 8'h0C, 8'h8C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h4C, 8'h88, 8'h84, 8'h40, 8'h00, 8'hFF},
      '{8'h80, 8'h00, 8'h0C, 8'h8C, 8'hFE, 8'h06, 8'h66, 8'hFF},
      '{8'h00, 8'h0C, 8'h8C, 8'hFE, 8'h06, 8'h66, 8'hFF, 8'hFF},
      '{8'h66, 8'h84, 8'h80, 8'h00, 8'h0C, 8'h8C, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'hFE, 8'h06, 8'h86, 8'hFE, 8'h8C, 8'h80},
      '{8'h00, 8'h80, 8'hFE, 8'h40, 8'h4C, 8'hFE, 8'h0C, 8'h8C},
      '{8'h04, 8'h40, 8'h80, 8'h8C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'hFE, 8'h8C, 8'h06, 8'h60, 8'hFF, 8'hFF},
      '{8'h80, 8'h00, 8'h0C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h48, 8'h8C, 8'h80, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h80, 8'h8C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h8C, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h8C, 8'h86, 8'h05, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h0C, 8'h8C, 8'h84, 8'h00, 8'hFE, 8'h44, 8'h80},
      '{8'h00, 8'h0C, 8'h8C, 8'h86, 8'h05, 8'hFE, 8'h45, 8'h80},
      '{8'h02, 8'h20, 8'h80, 8'h85, 8'h07, 8'h0C, 8'h6C, 8'h8A},
      '{8'h0C, 8'h8C, 8'hFE, 8'h4C, 8'h40, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h02, 8'h40, 8'h82, 8'h8C, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h40, 8'h8C, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h20, 8'h44, 8'h60, 8'h8C, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h8C, 8'hFE, 8'h0C, 8'h80, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h46, 8'h8C, 8'hFE, 8'h46, 8'h40, 8'hFF, 8'hFF},
      '{8'h0C, 8'h8C, 8'h00, 8'h80, 8'hFE, 8'h26, 8'h66, 8'hFF},
      '{8'h60, 8'h20, 8'h2C, 8'h6C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h0C, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h20, 8'h60, 8'h6C, 8'h2C, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h26, 8'h4C, 8'h66, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h2A, 8'h66, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'h60, 8'h42, 8'h4A, 8'h6C, 8'hFE, 8'h26, 8'h46, 8'hFF},
      '{8'h40, 8'h45, 8'hFE, 8'h46, 8'h4C, 8'hFF, 8'hFF, 8'hFF},
      '{8'h40, 8'h62, 8'h6A, 8'h4C, 8'hFE, 8'h66, 8'h86, 8'hFF},
      '{8'h04, 8'h28, 8'h64, 8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
   };

endpackage

[rtl/core/vsfg_req_if.sv]
// vsfg_req_if: request channel of the stroke font generator, valid/ready handshake
// no dependencies
interface vsfg_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       extents_only;

   modport source (output valid, output char_code, output extents_only, input ready);
   modport sink (input valid, input char_code, input extents_only, output ready);
endinterface

[rtl/core/vsfg_rsp_if.sv]
// vsfg_rsp_if: result channel of the stroke font generator, valid/ready handshake
// no dependencies
interface vsfg_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] start_x;
   logic [7:0] start_y;
   logic [7:0] end_x;
   logic [7:0] end_y;
   logic [8:0] advance;
   logic       last;

   modport source (output valid, output result_kind, output start_x, output start_y,
                   output end_x, output end_y, output advance, output last, input ready);
   modport sink (input valid, input result_kind, input start_x, input start_y,
                 input end_x, input end_y, input advance, input last, output ready);
endinterface

[rtl/core/vector_stroke_font_generator.sv]
// vector_stroke_font_generator: walks a glyph stroke table and emits line segments
// depends on vsfg_pkg, vsfg_req_if, vsfg_rsp_if
//
// usage:
//   req carries one character code and an extents_only flag per request.
//   rsp gives one line segment per pen-down point after the first, then one
//   advance result with last set. extents_only gives the advance alone.
//   csr is an apb write/read port; register 0 (byte address 0) is scale,
//   unsigned q4.4, 16 after reset. write it only while no request is open.
// timing:
//   a request is taken only when the block is idle. the glyph table is a
//   synchronous rom read one stroke entry per cycle while the walk is not
//   held, and the block is ready for a new request once the advance result
//   is registered. segment results come one per cycle while rsp.ready stays
//   high and no lift comes between.
// stall:
//   results sit in one output register; while a result waits with rsp.ready
//   low the walk holds on the current entry, lifts and skipped points still advance.
// reset:
//   synchronous, active high; returns to idle, drops rsp.valid, scale = 16.
module vector_stroke_font_generator
   import vsfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   vsfg_req_if.sink              req,
   vsfg_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic             state_ff, state_in;
   logic [7:0]       scale_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic             past_end_ff, past_end_in;
   logic             eo_ff, eo_in;
   logic             pen_ff, pen_in;
   logic [7:0]       px_ff, px_in;
   logic [7:0]       py_ff, py_in;
   logic [3:0]       maxx_ff, maxx_in;
   logic [7:0]       rom_q_ff;

   logic             out_valid_ff, out_valid_in;
   logic             out_kind_ff, out_kind_in;
   logic [7:0]       out_sx_ff, out_sx_in;
   logic [7:0]       out_sy_ff, out_sy_in;
   logic [7:0]       out_ex_ff, out_ex_in;
   logic [7:0]       out_ey_ff, out_ey_in;
   logic [8:0]       out_adv_ff, out_adv_in;
   logic             out_last_ff, out_last_in;

   logic             accept;
   logic             can_emit;
   logic [6:0]       code_fold;
   logic [ROW_W-1:0] row_new;
   logic             rd_en;
   logic [ROW_W-1:0] rd_row;
   logic [COL_W-1:0] rd_col;
   logic [7:0]       entry;
   logic             is_stop, is_lift, is_point;
   logic [3:0]       nx, ny;
   logic [11:0]      prod_x, prod_y, prod_top;
   logic [7:0]       cx, cy, top;
   logic [4:0]       wide;
   logic [12:0]      prod_adv;
   logic             emit_seg, consume, finish;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_SCALE) ? {24'd0, scale_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_SCALE)) begin
         scale_ff <= csr_pwdata[7:0];
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign can_emit  = !out_valid_ff || rsp.ready;

   // case fold, control codes map onto the blank space row
   always_comb begin
      code_fold = req.char_code;
      if (req.char_code inside {[LOWER_FIRST:LOWER_LAST]}) begin
         code_fold = req.char_code - FOLD_OFFSET;
      end
      if (code_fold < FIRST_CODE) begin
         row_new = '0;
      end else begin
         row_new = ROW_W'(code_fold - FIRST_CODE);
      end
   end

   assign entry    = past_end_ff ? STOP_CODE : rom_q_ff;
   assign is_stop  = (entry == STOP_CODE);
   assign is_lift  = (entry == LIFT_CODE);
   assign is_point = !is_stop && !is_lift;
   assign nx       = entry[7:4];
   assign ny       = entry[3:0];

   assign prod_x   = nx * scale_ff;
   assign prod_y   = ny * scale_ff;
   assign prod_top = CELL_UNITS * scale_ff;
   assign cx       = prod_x[11:4];
   assign top      = prod_top[11:4] + TOP_PAD;
   assign cy       = top - prod_y[11:4];

   assign wide     = ({1'b0, maxx_ff} + WIDE_PAD < MIN_WIDE) ? MIN_WIDE
                                                           : {1'b0, maxx_ff} + WIDE_PAD;
   assign prod_adv = wide * scale_ff;

   assign emit_seg = is_point && pen_ff && !eo_ff;
   assign consume  = (state_ff == ST_WALK) && (is_lift || (is_point && (!emit_seg || can_emit)));
   assign finish   = (state_ff == ST_WALK) && is_stop && can_emit;

   always_comb begin
      rd_en  = 1'b0;
      rd_row = row_ff;
      rd_col = col_ff[COL_W-1:0];
      if (accept) begin
         rd_en  = 1'b1;
         rd_row = row_new;
         rd_col = '0;
      end else if (consume && !col_ff[CNT_W-1]) begin
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rom_q_ff <= GLYPH_ROM[rd_row][rd_col];
      end
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      past_end_in = past_end_ff;
      eo_in       = eo_ff;
      pen_in      = pen_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      maxx_in     = maxx_ff;

      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_sx_in    = out_sx_ff;
      out_sy_in    = out_sy_ff;
      out_ex_in    = out_ex_ff;
      out_ey_in    = out_ey_ff;
      out_adv_in   = out_adv_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_WALK;
               row_in      = row_new;
               col_in      = CNT_W'(1);
               past_end_in = 1'b0;
               eo_in       = req.extents_only;
               pen_in      = 1'b0;
               maxx_in     = '0;
            end
         end
         ST_WALK: begin
            if (consume) begin
               past_end_in = col_ff[CNT_W-1];
               if (!col_ff[CNT_W-1]) begin
                  col_in = col_ff + CNT_W'(1);
               end
               if (is_lift) begin
                  pen_in = 1'b0;
               end else begin
                  pen_in = 1'b1;
                  px_in  = cx;
                  py_in  = cy;
                  if (nx > maxx_ff) begin
                     maxx_in = nx;
                  end
               end
               if (emit_seg) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = RESULT_SEGMENT;
                  out_sx_in    = px_ff;
                  out_sy_in    = py_ff;
                  out_ex_in    = cx;
                  out_ey_in    = cy;
                  out_adv_in   = '0;
                  out_last_in  = 1'b0;
               end
            end else if (finish) begin
               state_in     = ST_IDLE;
               out_valid_in = 1'b1;
               out_kind_in  = RESULT_ADVANCE;
               out_sx_in    = '0;
               out_sy_in    = '0;
               out_ex_in    = '0;
               out_ey_in    = '0;
               out_adv_in   = prod_adv[12:4];
               out_last_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      past_end_ff <= past_end_in;
      eo_ff       <= eo_in;
      pen_ff      <= pen_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      maxx_ff     <= maxx_in;
      out_kind_ff <= out_kind_in;
      out_sx_ff   <= out_sx_in;
      out_sy_ff   <= out_sy_in;
      out_ex_ff   <= out_ex_in;
      out_ey_ff   <= out_ey_in;
      out_adv_ff  <= out_adv_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_kind_ff;
   assign rsp.start_x     = out_sx_ff;
   assign rsp.start_y     = out_sy_ff;
   assign rsp.end_x       = out_ex_ff;
   assign rsp.end_y       = out_ey_ff;
   assign rsp.advance     = out_adv_ff;
   assign rsp.last        = out_last_ff;

endmodule

[test/vector_stroke_font_generator_tb.sv]
// vector_stroke_font_generator_tb: self-checking bench for the stroke font generator
// checks segments and advance results against a glyph predictor held in the bench
// depends on vsfg_pkg, vsfg_req_if, vsfg_rsp_if and vector_stroke_font_generator
module vector_stroke_font_generator_tb;
   import vsfg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] PEN_UP          = 8'hFE;
   localparam logic [7:0] GLYPH_END       = 8'hFF;
   localparam logic [6:0] PRINTABLE_FIRST = 7'h20;
   localparam logic [6:0] LOWER_A         = 7'h61;
   localparam logic [6:0] LOWER_Z         = 7'h7A;
   localparam logic [6:0] CASE_FOLD       = 7'h20;
   localparam int unsigned CELL_HEIGHT    = 12;
   localparam int unsigned MIN_ADVANCE    = 12;
   localparam int unsigned ADVANCE_PAD    = 4;
   localparam int unsigned BASE_PAD       = 2;
   localparam int unsigned MAX_SEGMENTS   = 7;
   localparam int          POINTS         = 8;
   localparam int          MAX_GAP        = 6;
   localparam logic [CSR_ADDR_W-1:0] SCALE_ADDR = CSR_ADDR_W'(4 * int'(REG_SCALE));

   typedef struct packed {
      logic       kind;
      logic [7:0] sx;
      logic [7:0] sy;
      logic [7:0] ex;
      logic [7:0] ey;
      logic [8:0] adv;
      logic       last;
   } stroke_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   vsfg_req_if req_bus ();
   vsfg_rsp_if rsp_bus ();

   vector_stroke_font_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   stroke_result_type expected_strokes[$];
   logic [7:0]     scale_now = 8'd16;
   bit             steady_flow = 1'b0;
   int             mismatch_count = 0;
   int             glyphs_sent = 0;
   int             strokes_checked = 0;
   int             segments_seen = 0;
   int             scale_settings = 1;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout: %0d results still outstanding", expected_strokes.size());
      $display("DONE: errors detected");
      $finish;
   end

   // stroke table, first point in the top byte, x in the high nibble
   function automatic logic [63:0] font_row(input logic [6:0] row);
      case (row)
         7'h01: return 64'h40325240FE444CFF;
         7'h02: return 64'h2A26FE6A66FFFFFF;
         7'h03: return 64'h0484626A88082A22;
         7'h04: return 64'h62266AFE4C40FFFF;
         7'h05: return 64'h008CFE2A28FE6462;
         7'h06: return 64'h804C88044084FFFF;
         7'h07: return 64'h266AFFFFFFFFFFFF;
         7'h08: return 64'h6024286CFFFFFFFF;
         7'h09: return 64'h2064682CFFFFFFFF;
         7'h0A: return 64'h004C80088800FFFF;
         7'h0B: return 64'h1676FE4943FFFFFF;
         7'h0C: return 64'h2042FFFFFFFFFFFF;
         7'h0D: return 64'h2666FFFFFFFFFFFF;
         7'h0E: return 64'h3040FFFFFFFFFFFF;
         7'h0F: return 64'h008CFFFFFFFFFFFF;
         7'h10: return 64'h00808C0C008CFFFF;
         7'h11: return 64'h404C3AFFFFFFFFFF;
         7'h12: return 64'h0C8C87050080FFFF;
         7'h13: return 64'h0C8C8000FE0686FF;
         7'h14: return 64'h0C0686FE8C80FFFF;
         7'h15: return 64'h008086070C8CFFFF;
         7'h16: return 64'h0C00808507FFFFFF;
         7'h17: return 64'h0C8C8640FFFFFFFF;
         7'h18: return 64'h00808C0C00FE0686;
         7'h19: return 64'h808C0C0785FFFFFF;
         7'h1A: return 64'h4947FE4543FFFFFF;
         7'h1B: return 64'h4947FE4512FFFFFF;
         7'h1C: return 64'h60266CFFFFFFFFFF;
         7'h1D: return 64'h1474FE1878FFFFFF;
         7'h1E: return 64'h20662CFFFFFFFFFF;
         7'h1F: return 64'h084C8844FE4140FF;
         7'h20: return 64'h844004084C884436;
         7'h21: return 64'h00084C8880FE0484;
         7'h22: return 64'h000C4C8A46824000;
         7'h23: return 64'h80000C8CFFFFFFFF;
         7'h24: return 64'h000C4C88844000FF;
         7'h25: return 64'h80000C8CFE0666FF;
         7'h26: return 64'h000C8CFE0666FFFF;
         7'h27: return 64'h668480000C8CFFFF;
         7'h28: return 64'h000CFE0686FE8C80;
         7'h29: return 64'h0080FE404CFE0C8C;
         7'h2A: return 64'h0440808CFFFFFFFF;
         7'h2B: return 64'h000CFE8C0660FFFF;
         7'h2C: return 64'h80000CFFFFFFFFFF;
         7'h2D: return 64'h000C488C80FFFFFF;
         7'h2E: return 64'h000C808CFFFFFFFF;
         7'h2F: return 64'h000C8C8000FFFFFF;
         7'h30: return 64'h000C8C8605FFFFFF;
         7'h31: return 64'h000C8C8400FE4480;
         7'h32: return 64'h000C8C8605FE4580;
         7'h33: return 64'h02208085070C6C8A;
         7'h34: return 64'h0C8CFE4C40FFFFFF;
         7'h35: return 64'h0C0240828CFFFFFF;
         7'h36: return 64'h0C408CFFFFFFFFFF;
         7'h37: return 64'h0C2044608CFFFFFF;
         7'h38: return 64'h008CFE0C80FFFFFF;
         7'h39: return 64'h0C468CFE4640FFFF;
         7'h3A: return 64'h0C8C0080FE2666FF;
         7'h3B: return 64'h60202C6CFFFFFFFF;
         7'h3C: return 64'h0C80FFFFFFFFFFFF;
         7'h3D: return 64'h20606C2CFFFFFFFF;
         7'h3E: return 64'h264C66FFFFFFFFFF;
         7'h3F: return 64'h0080FFFFFFFFFFFF;
         7'h40: return 64'h2A66FFFFFFFFFFFF;
         7'h5B: return 64'h60424A6CFE2646FF;
         7'h5C: return 64'h4045FE464CFFFFFF;
         7'h5D: return 64'h40626A4CFE6686FF;
         7'h5E: return 64'h04286488FFFFFFFF;
         default: return '1;
      endcase
   endfunction

   // queues the segments and the advance that one character produces
   function automatic void render_glyph(input logic [6:0] code, input logic extents);
      logic [6:0]     folded;
      logic [63:0]    strokes;
      logic [7:0]     entry;
      int unsigned    s, top, nx, ny, cx, cy, px, py, widest, wide, segs;
      bit             pen_down;
      stroke_result_type r;
      folded = code;
      if (folded >= LOWER_A && folded <= LOWER_Z) folded = folded - CASE_FOLD;
      strokes = (folded < PRINTABLE_FIRST) ? '1 : font_row(folded - PRINTABLE_FIRST);
      s = scale_now;
      top = ((CELL_HEIGHT * s) >> 4) + BASE_PAD;
      widest = 0;
      px = 0;
      py = 0;
      segs = 0;
      pen_down = 1'b0;
      for (int i = 0; i < POINTS; i++) begin
         entry = strokes[63 - 8 * i -: 8];
         if (entry == GLYPH_END) break;
         if (entry == PEN_UP) begin
            pen_down = 1'b0;
            continue;
         end
         nx = entry[7:4];
         ny = entry[3:0];
         if (nx > widest) widest = nx;
         cx = ((nx * s) >> 4) & 32'hFF;
         cy = (top - ((ny * s) >> 4)) & 32'hFF;
         if (pen_down && !extents && segs < MAX_SEGMENTS) begin
            r = '0;
            r.kind = RESULT_SEGMENT;
            r.sx = px[7:0];
            r.sy = py[7:0];
            r.ex = cx[7:0];
            r.ey = cy[7:0];
            expected_strokes.push_back(r);
            segs++;
         end
         px = cx;
         py = cy;
         pen_down = 1'b1;
      end
      wide = widest + ADVANCE_PAD;
      if (wide < MIN_ADVANCE) wide = MIN_ADVANCE;
      r = '0;
      r.kind = RESULT_ADVANCE;
      r.adv = ((wide * s) >> 4) & 32'h1FF;
      r.last = 1'b1;
      expected_strokes.push_back(r);
   endfunction

   function automatic int pick_gap();
      return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("ERROR @%0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string field, input logic [8:0] got, input logic [8:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   task automatic send_char(input logic [6:0] code, input logic extents);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= code;
      req_bus.extents_only <= extents;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      render_glyph(code, extents);
      glyphs_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_strokes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write scale, then read it back
   task automatic write_scale(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= SCALE_ADDR;
      csr_pwdata <= {24'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      scale_now = value;
      scale_settings++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== {24'b0, value})
         report_mismatch($sformatf("scale read %0h want %0h", csr_prdata, value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stroke_checker
      stroke_result_type want;
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_strokes.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_strokes.pop_front();
            check_field("result_kind", rsp_bus.result_kind, want.kind);
            check_field("start_x", rsp_bus.start_x, want.sx);
            check_field("start_y", rsp_bus.start_y, want.sy);
            check_field("end_x", rsp_bus.end_x, want.ex);
            check_field("end_y", rsp_bus.end_y, want.ey);
            check_field("advance", rsp_bus.advance, want.adv);
            check_field("last", rsp_bus.last, want.last);
            if (want.kind == RESULT_SEGMENT) segments_seen++;
         end
         strokes_checked++;
      end
   end

   // glyphs at the reset scale: fold, blanks, lifts, full rows, extents-only requests
   task automatic test_reset_scale_glyphs();
      logic [7:0] picks[] = '{
         8'h20, 8'h41, 8'h61, 8'h7A, 8'h5A, 8'h42, 8'h23, 8'h25,
         8'h00, 8'h1F, 8'h7F, 8'h60, 8'h7B, 8'h7E, 8'h21, 8'h53,
         8'hC2, 8'hD7, 8'h9F, 8'hFE
      };
      foreach (picks[i]) send_char(picks[i][6:0], picks[i][7]);
   endtask

   // largest, smallest and zero scale, one stretch without idling
   task automatic test_scale_extremes();
      logic [7:0] levels[] = '{8'd255, 8'd1, 8'd0};
      logic [7:0] picks[] = '{8'h42, 8'h23, 8'h57, 8'h61, 8'h05, 8'h7F, 8'hC8, 8'h38};
      foreach (levels[l]) begin
         wait_idle();
         write_scale(levels[l]);
         steady_flow = (l == 0);
         foreach (picks[i]) send_char(picks[i][6:0], picks[i][7]);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_text();
      logic [6:0] code;
      for (int n = 0; n < 66; n++) begin
         if (n % 22 == 0) begin
            wait_idle();
            write_scale(8'($urandom_range(1, 255)));
            steady_flow = (n == 44);
         end else if ($urandom_range(0, 11) == 0) begin
            wait_idle();
         end
         if ($urandom_range(0, 9) < 7) code = 7'($urandom_range(32, 127));
         else code = 7'($urandom_range(0, 127));
         send_char(code, $urandom_range(0, 3) == 0);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.char_code <= '0;
      req_bus.extents_only <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_scale_glyphs();
      test_scale_extremes();
      test_random_text();
      wait_idle();
      repeat (12) @(posedge clock);
      $display("rendered %0d characters over %0d scale settings", glyphs_sent, scale_settings);
      $display("checked %0d results, %0d of them segments", strokes_checked, segments_seen);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
